>>> rtl/skl_pkg.sv
// Shared types and constants for the sorted key limit table.
// No dependencies; the table module imports everything from here.
package skl_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic {
      ACTION_INSERT = 1'b0,
      ACTION_LOOKUP = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_MISSING = 2'd2
   } status_type;

   typedef struct packed {
      action_type  action;
      logic [15:0] key;
      logic [31:0] first_limit;
      logic [31:0] second_limit;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] found_first_limit;
      logic [31:0] found_second_limit;
   } rsp_type;

   typedef struct packed {
      logic [15:0] key;
      logic [31:0] first_limit;
      logic [31:0] second_limit;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SRCH_ADDR,
      ST_SRCH_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PLACE,
      ST_RESP
   } state_type;

endpackage

>>> rtl/sorted_key_limit_table.sv
// Sorted key limit table: entry memory with one read port and one write
// port, a binary search and shift-insert sequencer. Depends on skl_pkg.
//
//  channel | ports                         | word
//  --------+-------------------------------+-----------------------------
//  request | req_valid, req_ready, req_data | action, key, two limits
//  result  | rsp_valid, rsp_ready, rsp_data | status, two found limits
//
// One word at a time. Lookup: each search step is a read, then a compare,
// with at most 7 steps. Insert: search, then each entry moved up by one
// slot takes one memory read and one memory write. A full insert skips the
// search and answers STATUS_FULL. Reset clears the entry count; the memory
// is not cleared. A stalled result holds in its register until rsp_ready.
module sorted_key_limit_table
   import skl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   entry_type entry_mem [CAPACITY];

   state_type            state_ff, state_in;
   req_type              req_ff;
   rsp_type              rsp_ff, rsp_in;
   entry_type            rd_data_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]     hi_ff, hi_in;
   logic [CNT_W-1:0]     mid_ff, mid_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;

   logic [IDX_W-1:0]     rd_addr;
   logic [IDX_W-1:0]     wr_addr;
   entry_type            wr_data;
   logic                 wr_en;

   logic                 is_full;
   logic                 search_done;
   logic                 key_eq;
   logic                 key_gt;
   logic [CNT_W-1:0]     mid_calc;
   logic [CNT_W-1:0]     idx_dec;

   assign is_full     = (count_ff >= CNT_W'(CAPACITY));
   assign search_done = (lo_ff >= hi_ff);
   assign key_eq      = (rd_data_ff.key == req_ff.key);
   assign key_gt      = (rd_data_ff.key > req_ff.key);
   assign mid_calc    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_dec     = idx_ff - CNT_W'(1);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data  = rsp_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (req_ff.action == ACTION_INSERT && is_full) state_in = ST_RESP;
            else state_in = ST_SRCH_ADDR;
         end
         ST_SRCH_ADDR: begin
            if (!search_done) state_in = ST_SRCH_CMP;
            else if (req_ff.action == ACTION_LOOKUP) state_in = ST_RESP;
            else if (count_ff > lo_ff) state_in = ST_SHIFT_RD;
            else state_in = ST_PLACE;
         end
         ST_SRCH_CMP: begin
            if (key_eq) state_in = ST_RESP;
            else state_in = ST_SRCH_ADDR;
         end
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: begin
            if (idx_dec > lo_ff) state_in = ST_SHIFT_RD;
            else state_in = ST_PLACE;
         end
         ST_PLACE: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath controls
   always_comb begin
      rsp_in   = rsp_ff;
      count_in = count_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      idx_in   = idx_ff;
      rd_addr  = mid_calc[IDX_W-1:0];
      wr_addr  = idx_ff[IDX_W-1:0];
      wr_data  = rd_data_ff;
      wr_en    = 1'b0;
      unique case (state_ff)
         ST_IDLE: ;
         ST_CHECK: begin
            lo_in = '0;
            hi_in = count_ff;
            rsp_in.found_first_limit  = '0;
            rsp_in.found_second_limit = '0;
            rsp_in.status = (req_ff.action == ACTION_INSERT && is_full) ?
                            STATUS_FULL : STATUS_OK;
         end
         ST_SRCH_ADDR: begin
            mid_in = mid_calc;
            idx_in = count_ff;
            if (search_done && req_ff.action == ACTION_LOOKUP) begin
               rsp_in.status = STATUS_MISSING;
            end
         end
         ST_SRCH_CMP: begin
            if (key_eq) begin
               if (req_ff.action == ACTION_LOOKUP) begin
                  rsp_in.found_first_limit  = rd_data_ff.first_limit;
                  rsp_in.found_second_limit = rd_data_ff.second_limit;
               end
            end else if (key_gt) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + CNT_W'(1);
            end
         end
         ST_SHIFT_RD: begin
            rd_addr = idx_dec[IDX_W-1:0];
         end
         ST_SHIFT_WR: begin
            // move the entry just read up by one slot
            wr_en  = 1'b1;
            idx_in = idx_dec;
         end
         ST_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff[IDX_W-1:0];
            wr_data.key          = req_ff.key;
            wr_data.first_limit  = req_ff.first_limit;
            wr_data.second_limit = req_ff.second_limit;
            count_in = count_ff + CNT_W'(1);
         end
         ST_RESP: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
      rsp_ff <= rsp_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) entry_mem[wr_addr] <= wr_data;
      rd_data_ff <= entry_mem[rd_addr];
   end

endmodule
